// ===== rtl/cau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_DIV0 = 2'd1,
    STAT_SAT  = 2'd2
  } status_t;

  localparam int unsigned NUM_W = 48;
  localparam int unsigned DEN_W = 32;

  // item info carried alongside the divider
  typedef struct packed {
    logic               valid;
    logic               is_div;
    logic               zero;
    logic               neg_re;
    logic               neg_im;
    logic signed [32:0] re;
    logic signed [32:0] im;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/cau_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cau_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cau_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic      [NW-1:0] quo
);

  logic [NW-1:0] nq   [1:NW];
  logic [DW-1:0] rem  [1:NW-1];
  logic [DW-1:0] dd   [1:NW-1];
  logic [NW-1:0] q_in [0:NW-1];
  logic [DW-1:0] r_in [0:NW-1];
  logic [DW-1:0] d_in [0:NW-1];
  logic [DW:0]   trial[0:NW-1];
  logic [DW-1:0] diff [0:NW-1];
  logic          ge   [0:NW-1];

  always_comb begin
    q_in[0] = num;
    r_in[0] = '0;
    d_in[0] = den;
    for (int i = 1; i < NW; i++) begin
      q_in[i] = nq[i];
      r_in[i] = rem[i];
      d_in[i] = dd[i];
    end
    for (int i = 0; i < NW; i++) begin
      trial[i] = {r_in[i], q_in[i][NW-1]};
      diff[i]  = trial[i][DW-1:0] - d_in[i];
      ge[i]    = trial[i] >= {1'b0, d_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      nq[i+1] <= {q_in[i][NW-2:0], ge[i]};
    end
    for (int i = 0; i < NW-1; i++) begin
      rem[i+1] <= ge[i] ? diff[i] : trial[i][DW-1:0];
      dd[i+1]  <= d_in[i];
    end
  end

  assign quo = nq[NW];

endmodule
`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Complex add, subtract, multiply and divide on Q8.8 operands, Q16.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   An item (func, a_re, a_im, b_re, b_im) is taken on a clock edge with
//   start high and busy low. busy is always low: one item per cycle.
//   Each item yields one result on res_re, res_im, status, shown for one
//   cycle with done high. Results leave in the order items came in.
//   Every function passes the same registers from the accepting edge to the
//   edge that takes the result: input register, products, sums, 48 stages
//   of the bit-per-stage divider, output register. All items pass the
//   divider pipeline so the order and spacing hold.
//   Throughput is one item per cycle.
//   Reset clears the valid bits; items in flight are dropped.
//   The receiver cannot stall; done is never held off.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         func,
  input  wire logic signed [15:0] a_re,
  input  wire logic signed [15:0] a_im,
  input  wire logic signed [15:0] b_re,
  input  wire logic signed [15:0] b_im,
  output logic                    done,
  output logic signed [31:0]      res_re,
  output logic signed [31:0]      res_im,
  output logic [1:0]              status
);

  localparam int unsigned NW = cau_pkg::NUM_W;
  localparam int unsigned DW = cau_pkg::DEN_W;

  assign busy = 1'b0;

  // stage 1: input registers
  logic                v1;
  logic [1:0]          f1;
  logic signed [15:0]  ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    f1  <= func;
    ar1 <= a_re;
    ai1 <= a_im;
    br1 <= b_re;
    bi1 <= b_im;
  end

  // stage 2: products and add/sub
  logic                v2;
  logic [1:0]          f2;
  logic signed [31:0]  p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
  logic signed [32:0]  as_re, as_im;
  logic signed [16:0]  s_re, s_im;

  always_comb begin
    if (f1 == cau_pkg::FUNC_SUB) begin
      s_re = 17'(ar1) - 17'(br1);
      s_im = 17'(ai1) - 17'(bi1);
    end else begin
      s_re = 17'(ar1) + 17'(br1);
      s_im = 17'(ai1) + 17'(bi1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    f2    <= f1;
    p_rr  <= ar1 * br1;
    p_ii  <= ai1 * bi1;
    p_ri  <= ar1 * bi1;
    p_ir  <= ai1 * br1;
    p_bb  <= br1 * br1;
    p_cc  <= bi1 * bi1;
    as_re <= 33'(s_re) <<< 8;
    as_im <= 33'(s_im) <<< 8;
  end

  // stage 3: sums, magnitudes, divisor
  logic signed [32:0]  n_re, n_im, m_re, m_im, a_nre, a_nim;
  logic [DW-1:0]       den_c;
  cau_pkg::side_t      side3;
  logic [NW-1:0]       num_re3, num_im3;
  logic [DW-1:0]       den3;

  always_comb begin
    n_re  = 33'(p_rr) + 33'(p_ii);
    n_im  = 33'(p_ir) - 33'(p_ri);
    m_re  = 33'(p_rr) - 33'(p_ii);
    m_im  = 33'(p_ri) + 33'(p_ir);
    a_nre = n_re[32] ? -n_re : n_re;
    a_nim = n_im[32] ? -n_im : n_im;
    den_c = DW'(p_bb) + DW'(p_cc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side3.valid <= 1'b0;
    end else begin
      side3.valid <= v2;
    end
    side3.is_div <= (f2 == cau_pkg::FUNC_DIV);
    side3.zero   <= (den_c == '0);
    side3.neg_re <= n_re[32];
    side3.neg_im <= n_im[32];
    side3.re     <= (f2 == cau_pkg::FUNC_MUL) ? m_re : as_re;
    side3.im     <= (f2 == cau_pkg::FUNC_MUL) ? m_im : as_im;
    num_re3      <= {a_nre[31:0], 16'h0000};
    num_im3      <= {a_nim[31:0], 16'h0000};
    den3         <= den_c;
  end

  // divider stages
  logic [NW-1:0] q_re, q_im;

  cau_div #(.NW(NW), .DW(DW)) u_div_re (
    .clk (clk),
    .num (num_re3),
    .den (den3),
    .quo (q_re)
  );

  cau_div #(.NW(NW), .DW(DW)) u_div_im (
    .clk (clk),
    .num (num_im3),
    .den (den3),
    .quo (q_im)
  );

  cau_pkg::side_t side [1:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= NW; i++) begin
        side[i] <= '0;
      end
    end else begin
      side[1] <= side3;
      for (int i = 1; i < NW; i++) begin
        side[i+1] <= side[i];
      end
    end
  end

  // final: sign, clip, status
  cau_pkg::side_t       sd;
  logic signed [NW:0]   v_re, v_im;
  logic signed [31:0]   c_re, c_im;
  logic                 k_re, k_im;
  logic signed [31:0]   o_re, o_im;
  logic [1:0]           o_st;

  localparam logic signed [NW:0] MAXV = (NW+1)'(32'sh7fffffff);
  localparam logic signed [NW:0] MINV = -(NW+1)'(33'sh080000000);

  always_comb begin
    sd = side[NW];
    if (sd.is_div) begin
      v_re = sd.neg_re ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
      v_im = sd.neg_im ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});
    end else begin
      v_re = (NW+1)'(sd.re);
      v_im = (NW+1)'(sd.im);
    end
    k_re = (v_re > MAXV) || (v_re < MINV);
    k_im = (v_im > MAXV) || (v_im < MINV);
    c_re = (v_re > MAXV) ? 32'sh7fffffff :
           (v_re < MINV) ? 32'sh80000000 : v_re[31:0];
    c_im = (v_im > MAXV) ? 32'sh7fffffff :
           (v_im < MINV) ? 32'sh80000000 : v_im[31:0];
    if (sd.is_div && sd.zero) begin
      o_re = '0;
      o_im = '0;
      o_st = cau_pkg::STAT_DIV0;
    end else begin
      o_re = c_re;
      o_im = c_im;
      o_st = (k_re || k_im) ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd.valid;
    end
    res_re <= o_re;
    res_im <= o_im;
    status <= o_st;
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for complex_arithmetic_unit: directed corner operands
// per function, then random items with random gaps. Every result is compared
// against a built-in arithmetic predictor, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LATENCY = 52;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    cau_pkg::status_t   st;
  } cresult_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;
  logic               done;
  logic signed [31:0] res_re;
  logic signed [31:0] res_im;
  logic [1:0]         status;

  cresult_t pending_q[$];
  int       mismatch_count;
  int       idle_cycles;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .done(done), .res_re(res_re), .res_im(res_im), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                inout logic clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic cresult_t complex_op(cau_pkg::func_t f, logic signed [15:0] xr,
      logic signed [15:0] xi, logic signed [15:0] yr, logic signed [15:0] yi);
    logic signed [63:0] ar, ai, br, bi, re, im, den;
    logic clipped;
    cresult_t r;
    ar = xr; ai = xi; br = yr; bi = yi;
    re = 0; im = 0; clipped = 1'b0;
    r.re = 0; r.im = 0; r.st = cau_pkg::STAT_OK;
    case (f)
      cau_pkg::FUNC_ADD: begin re = (ar + br) * 256; im = (ai + bi) * 256; end
      cau_pkg::FUNC_SUB: begin re = (ar - br) * 256; im = (ai - bi) * 256; end
      cau_pkg::FUNC_MUL: begin re = ar * br - ai * bi; im = ar * bi + ai * br; end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) r.st = cau_pkg::STAT_DIV0;
        else begin
          re = ((ar * br + ai * bi) * 65536) / den;
          im = ((ai * br - ar * bi) * 65536) / den;
        end
      end
    endcase
    if (r.st == cau_pkg::STAT_OK) begin
      r.re = clip32(re, clipped);
      r.im = clip32(im, clipped);
      if (clipped) r.st = cau_pkg::STAT_SAT;
    end
    return r;
  endfunction

  // gap 0 keeps start high from the previous item
  task automatic send_item(cau_pkg::func_t f, logic signed [15:0] xr,
                           logic signed [15:0] xi, logic signed [15:0] yr,
                           logic signed [15:0] yi, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f; a_re <= xr; a_im <= xi; b_re <= yr; b_im <= yi;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(complex_op(f, xr, xi, yr, yi));
  endtask

  task automatic send_random(cau_pkg::func_t f, int gap);
    logic [15:0] v[4];
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: v[i] = 16'h8000;
        1: v[i] = 16'h7fff;
        2: v[i] = 16'($signed($urandom_range(0, 8)) - 4);
        3: v[i] = 16'($signed($urandom_range(0, 1023)) - 512);
        default: v[i] = 16'($urandom);
      endcase
    end
    send_item(f, v[0], v[1], v[2], v[3], gap);
  endtask

  always @(posedge clk) begin
    if (rst) idle_cycles <= 0;
    else if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %0d %0d %0d",
                                           res_re, res_im, status);
      end else begin
        cresult_t e;
        e = pending_q.pop_front();
        if (e.re !== res_re || e.im !== res_im || e.st !== status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                     e.re, e.im, e.st, res_re, res_im, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_add_sub();
    send_item(cau_pkg::FUNC_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_item(cau_pkg::FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_item(cau_pkg::FUNC_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1);
    send_item(cau_pkg::FUNC_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 0);
    send_item(cau_pkg::FUNC_ADD, 16'sh0000, 16'shffff, 16'sh0001, 16'sh0000, 2);
  endtask

  task automatic test_multiply();
    send_item(cau_pkg::FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 0);
    send_item(cau_pkg::FUNC_MUL, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 0);
    send_item(cau_pkg::FUNC_MUL, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_item(cau_pkg::FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 3);
    send_item(cau_pkg::FUNC_MUL, 16'sh0100, 16'sh0200, 16'shfd00, 16'sh0100, 0);
  endtask

  task automatic test_divide();
    send_item(cau_pkg::FUNC_DIV, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000, 0);
    send_item(cau_pkg::FUNC_DIV, 16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000, 0);
    send_item(cau_pkg::FUNC_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'shffff, 0);
    send_item(cau_pkg::FUNC_DIV, 16'sh0100, 16'sh0000, 16'sh0300, 16'sh0000, 2);
    send_item(cau_pkg::FUNC_DIV, 16'shff00, 16'sh0100, 16'sh0300, 16'shfe00, 0);
    send_item(cau_pkg::FUNC_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0);
    send_item(cau_pkg::FUNC_DIV, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh7fff, 1);
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    send_random(cau_pkg::FUNC_DIV, 0);
  endtask

  task automatic test_random();
    for (int n = 0; n < 750; n++) begin
      int gap;
      gap = (n % 150 < 40) ? 0 : $urandom_range(0, 10);
      send_random(cau_pkg::func_t'($urandom_range(0, 3)), gap);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = cau_pkg::FUNC_ADD;
    a_re = '0; a_im = '0; b_re = '0; b_im = '0;
    mismatch_count = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_add_sub();
    test_multiply();
    test_divide();
    test_drain_pause();
    test_random();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit.sv
verif/testbench.sv
